>>> rtl/mbda_pkg.sv
`default_nettype none
package mbda_pkg;

	localparam int BUTTON_COUNT = 3;
	localparam int HISTORY_BITS = 8;
	localparam int ELAPSED_BITS = 17;

	localparam int HIST_CNT_W = $clog2(HISTORY_BITS + 1);
	localparam int PRESS_THRESHOLD = 4;
	localparam int RELEASE_THRESHOLD = 4;
	localparam int WAKE_HISTORY = 4;
	localparam int TICKS_PER_UNIT = 500;

	localparam int TIMEOUT_W = 8;
	localparam int CFG_DATA_W = 8;

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_WAKE = 1'b1
	} req_t;

	typedef enum logic {
		CFG_HANDLER_PRESENT = 1'b0,
		CFG_SLEEP_TIMEOUT   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic step;
		logic wake;
		logic pressed;
		logic accepts;
		logic present;
	} btn_ctrl_t;

	typedef struct packed {
		logic stable;
		logic call;
		logic in_window;
	} btn_stat_t;

endpackage
`default_nettype wire

>>> rtl/mbda_button.sv
`default_nettype none
module mbda_button import mbda_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire btn_ctrl_t               ctrl,
	input  wire logic [ELAPSED_BITS-1:0] limit,
	output btn_stat_t                    stat
);

	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

	logic [HISTORY_BITS-1:0] history_q, history_d, hist_shift;
	logic                    recorded_q, recorded_d;
	logic                    done_q, done_d;
	logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [HIST_CNT_W-1:0]   ones;
	logic                    stable, call, release_hit;

	always_comb begin
		ones = '0;
		for (int i = 0; i < HISTORY_BITS; i++) begin
			ones = ones + HIST_CNT_W'(hist_shift[i]);
		end
	end

	always_comb begin
		hist_shift  = {history_q[HISTORY_BITS-2:0], ctrl.pressed};
		elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
		stable      = ctrl.pressed && (ones >= HIST_CNT_W'(PRESS_THRESHOLD));
		call        = stable && !done_q && ctrl.present;
		release_hit = !ctrl.pressed && (ones <= HIST_CNT_W'(RELEASE_THRESHOLD));

		if (ctrl.wake) begin
			history_d  = HISTORY_BITS'(WAKE_HISTORY);
			recorded_d = 1'b1;
			done_d     = 1'b1;
			elapsed_d  = '0;
		end else begin
			history_d  = hist_shift;
			elapsed_d  = (stable && !recorded_q) ? '0 : elapsed_inc;
			recorded_d = stable ? 1'b1 : (release_hit ? 1'b0 : recorded_q);
			done_d     = (call && ctrl.accepts) ? 1'b1 : (release_hit ? 1'b0 : done_q);
		end

		stat.stable    = stable && !ctrl.wake;
		stat.call      = call && !ctrl.wake;
		// activity is judged on the count after this update
		stat.in_window = elapsed_d < limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q  <= '0;
			recorded_q <= 1'b0;
			done_q     <= 1'b0;
			elapsed_q  <= '0;
		end else if (ctrl.step) begin
			history_q  <= history_d;
			recorded_q <= recorded_d;
			done_q     <= done_d;
			elapsed_q  <= elapsed_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/multi_button_debounce_activity.sv
`default_nettype none
// An accepted transaction passes through the input register, then the
// per-button update into the result register.
// Throughput: one item per cycle while m_axis_tready is high; a waiting result
// lets one more transaction into the input register, then s_axis_tready drops.
// Reset (arst_n low) clears histories, flags, elapsed counts, valid bits and config registers.
module multi_button_debounce_activity import mbda_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata,  // [2:0] key_levels, [5:3] handler_accepts
	input  wire logic                  s_axis_tuser,  // [0] req_type
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [7:0]                 m_axis_tdata,  // [2:0] stable_pressed, [5:3] handler_calls,
	                                                  // [6] user_active
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic                    valid_s1;
	req_t                    type_s1;
	logic [BUTTON_COUNT-1:0] keys_s1, accepts_s1;
	logic                    valid_s2;
	logic [BUTTON_COUNT-1:0] stable_s2, calls_s2;
	logic                    active_s2;

	logic [BUTTON_COUNT-1:0] present_q;
	logic [ELAPSED_BITS-1:0] limit_q;

	logic                    adv_s1;
	btn_ctrl_t               ctrl [BUTTON_COUNT];
	btn_stat_t               stat [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] stable_c, calls_c, window_c;

	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, active_s2, calls_s2, stable_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			limit_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HANDLER_PRESENT: present_q <= cfg_data[BUTTON_COUNT-1:0];
				CFG_SLEEP_TIMEOUT:   limit_q   <= ELAPSED_BITS'(cfg_data[TIMEOUT_W-1:0])
				                                * ELAPSED_BITS'(TICKS_PER_UNIT);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			type_s1    <= req_t'(s_axis_tuser);
			keys_s1    <= s_axis_tdata[BUTTON_COUNT-1:0];
			accepts_s1 <= s_axis_tdata[2*BUTTON_COUNT-1:BUTTON_COUNT];
		end
	end

	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_btn
		always_comb begin
			ctrl[b].step    = adv_s1;
			ctrl[b].wake    = (type_s1 == REQ_WAKE);
			ctrl[b].pressed = !keys_s1[b];
			ctrl[b].accepts = accepts_s1[b];
			ctrl[b].present = present_q[b];
			stable_c[b]     = stat[b].stable;
			calls_c[b]      = stat[b].call;
			window_c[b]     = stat[b].in_window;
		end

		mbda_button u_button (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl[b]),
			.limit  (limit_q),
			.stat   (stat[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			stable_s2 <= stable_c;
			calls_s2  <= calls_c;
			// zero limit means the timeout is off
			active_s2 <= (limit_q == '0) || (|window_c);
		end
	end

endmodule
`default_nettype wire
